// ===== rtl/sep_pkg.sv =====
package sep_pkg;

   typedef logic signed [63:0] q60_type;

   localparam int FRAC = 60;
   localparam int SQRT_BITS = 61;

   localparam q60_type ONE_Q60 = 64'sh1000_0000_0000_0000;
   localparam q60_type INV2PI_Q60 = 64'sh028B_E60D_B939_1054;
   localparam q60_type GAIN_Q60 = 64'sh0000_0009_B74E_DA80 <<< 24;
   localparam logic [63:0] INV2PI_Q64 = 64'h28BE_60DB_9391_054A;

   localparam logic [2:0] CSR_ECC_BASE = 3'd0;
   localparam logic [2:0] CSR_ECC_RATE = 3'd1;
   localparam logic [2:0] CSR_ANOM_BASE = 3'd2;
   localparam logic [2:0] CSR_ANOM_RATE = 3'd3;
   localparam logic [2:0] CSR_PERI_BASE = 3'd4;
   localparam logic [2:0] CSR_PERI_RATE = 3'd5;

   // long division for elaboration-time constants only
   function automatic logic [63:0] const_udiv(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int k = 63; k >= 0; k--) begin
         rem = {rem[63:0], num[k]};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[k] = 1'b1;
         end
      end
      return quo;
   endfunction

   // arctangent of 2^-i in turns, Q0.64
   function automatic logic [63:0] atan_turn(input int unsigned i);
      logic [63:0] s;
      logic [63:0] t;
      logic [127:0] p;
      int unsigned n;
      s = '0;
      if (i == 0) begin
         return 64'h2000_0000_0000_0000;
      end
      for (n = 1; i * n < 64; n = n + 2) begin
         t = const_udiv(64'd1 << (64 - i * n), 64'(n));
         if (n[1]) begin
            s = s - t;
         end else begin
            s = s + t;
         end
      end
      p = {64'd0, s} * {64'd0, INV2PI_Q64};
      return p[127:64];
   endfunction

endpackage

// ===== rtl/sep_req_if.sv =====
interface sep_req_if;
   logic valid;
   logic ready;
   logic signed [20:0] day_number;

   modport source (output valid, output day_number, input ready);
   modport sink (input valid, input day_number, output ready);
endinterface

// ===== rtl/sep_rsp_if.sv =====
interface sep_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] x_pos;
   logic signed [31:0] y_pos;

   modport source (output valid, output x_pos, output y_pos, input ready);
   modport sink (input valid, input x_pos, input y_pos, output ready);
endinterface

// ===== rtl/sep_delay.sv =====
module sep_delay #(
   parameter int W = 64,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);

   generate
      if (DEPTH == 0) begin : g_none
         assign q = d;
      end else begin : g_pipe
         logic [W-1:0] pipe_ff [DEPTH];

         always_ff @(posedge clock) begin
            if (en) begin
               pipe_ff[0] <= d;
               for (int k = 1; k < DEPTH; k++) begin
                  pipe_ff[k] <= pipe_ff[k-1];
               end
            end
         end

         assign q = pipe_ff[DEPTH-1];
      end
   endgenerate

endmodule

// ===== rtl/sep_mul.sv =====
// Q3.60 product, sign and magnitude, magnitude truncated; registered
module sep_mul (
   input  logic             clock,
   input  logic             en,
   input  sep_pkg::q60_type a,
   input  sep_pkg::q60_type b,
   output sep_pkg::q60_type p
);

   logic [63:0] ua_ff, ub_ff;
   logic        neg1_ff, neg2_ff;
   logic [63:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic [127:0] sum;
   logic [63:0]  mag;
   sep_pkg::q60_type p_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ua_ff   <= a[63] ? 64'(-a) : 64'(a);
         ub_ff   <= b[63] ? 64'(-b) : 64'(b);
         neg1_ff <= a[63] ^ b[63];
         p00_ff  <= 64'(ua_ff[31:0]) * 64'(ub_ff[31:0]);
         p01_ff  <= 64'(ua_ff[31:0]) * 64'(ub_ff[63:32]);
         p10_ff  <= 64'(ua_ff[63:32]) * 64'(ub_ff[31:0]);
         p11_ff  <= 64'(ua_ff[63:32]) * 64'(ub_ff[63:32]);
         neg2_ff <= neg1_ff;
         p_ff    <= neg2_ff ? -signed'(mag) : signed'(mag);
      end
   end

   assign sum = {64'd0, p00_ff} + ({64'd0, p01_ff} << 32) + ({64'd0, p10_ff} << 32)
              + {p11_ff, 64'd0};
   assign mag = {1'b0, sum[122:60]};
   assign p   = p_ff;

endmodule

// ===== rtl/sep_cordic_cell.sv =====
module sep_cordic_cell #(
   parameter int          AB       = 32,
   parameter int          SHIFT    = 0,
   parameter logic [63:0] ATAN_Q64 = 64'd0
) (
   input  logic             clock,
   input  logic             en,
   input  sep_pkg::q60_type in_x,
   input  sep_pkg::q60_type in_y,
   input  logic signed [AB:0] in_z,
   output sep_pkg::q60_type out_x,
   output sep_pkg::q60_type out_y,
   output logic signed [AB:0] out_z
);

   localparam logic signed [AB:0] ATAN = signed'({1'b0, ATAN_Q64[63 -: AB]});

   sep_pkg::q60_type   x_ff, y_ff;
   logic signed [AB:0] z_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (!in_z[AB]) begin
            x_ff <= in_x - (in_y >>> SHIFT);
            y_ff <= in_y + (in_x >>> SHIFT);
            z_ff <= in_z - ATAN;
         end else begin
            x_ff <= in_x + (in_y >>> SHIFT);
            y_ff <= in_y - (in_x >>> SHIFT);
            z_ff <= in_z + ATAN;
         end
      end
   end

   assign out_x = x_ff;
   assign out_y = y_ff;
   assign out_z = z_ff;

endmodule

// ===== rtl/sep_cordic.sv =====
// vector rotation: one fold stage then one cell per micro-rotation
module sep_cordic #(
   parameter int AB = 32,
   parameter int CS = 32
) (
   input  logic             clock,
   input  logic             en,
   input  sep_pkg::q60_type src_x,
   input  sep_pkg::q60_type src_y,
   input  logic [AB-1:0]    src_ang,
   output sep_pkg::q60_type res_x,
   output sep_pkg::q60_type res_y
);

   localparam logic signed [AB:0] QUARTER = (AB+1)'(1) <<< (AB - 2);
   localparam logic signed [AB:0] HALF    = (AB+1)'(1) <<< (AB - 1);

   sep_pkg::q60_type   xs [CS+1];
   sep_pkg::q60_type   ys [CS+1];
   logic signed [AB:0] zs [CS+1];
   logic signed [AB:0] z0;
   sep_pkg::q60_type   x0_ff, y0_ff;
   logic signed [AB:0] z0_ff;

   assign z0 = signed'({src_ang[AB-1], src_ang});

   // fold into a half turn about zero, negating the vector when the angle is moved
   always_ff @(posedge clock) begin
      if (en) begin
         if (z0 > QUARTER) begin
            z0_ff <= z0 - HALF;
            x0_ff <= -src_x;
            y0_ff <= -src_y;
         end else if (z0 < -QUARTER) begin
            z0_ff <= z0 + HALF;
            x0_ff <= -src_x;
            y0_ff <= -src_y;
         end else begin
            z0_ff <= z0;
            x0_ff <= src_x;
            y0_ff <= src_y;
         end
      end
   end

   assign xs[0] = x0_ff;
   assign ys[0] = y0_ff;
   assign zs[0] = z0_ff;

   generate
      for (genvar i = 0; i < CS; i++) begin : g_cell
         localparam logic [63:0] AT = sep_pkg::atan_turn(i);
         sep_cordic_cell #(.AB(AB), .SHIFT(i), .ATAN_Q64(AT)) u_cell (
            .clock (clock),
            .en    (en),
            .in_x  (xs[i]),
            .in_y  (ys[i]),
            .in_z  (zs[i]),
            .out_x (xs[i+1]),
            .out_y (ys[i+1]),
            .out_z (zs[i+1])
         );
      end
   endgenerate

   assign res_x = xs[CS];
   assign res_y = ys[CS];

endmodule

// ===== rtl/sep_sqrt_cell.sv =====
// one result bit of the digit-by-digit square root
module sep_sqrt_cell #(
   parameter int BIT = 60
) (
   input  logic         clock,
   input  logic         en,
   input  logic [123:0] in_rem,
   input  logic [60:0]  in_root,
   output logic [123:0] out_rem,
   output logic [60:0]  out_root
);

   logic [123:0] trial;
   logic [123:0] rem_ff;
   logic [60:0]  root_ff;

   assign trial = (124'(in_root) << (BIT + 1)) | (124'd1 << (2 * BIT));

   always_ff @(posedge clock) begin
      if (en) begin
         if (trial <= in_rem) begin
            rem_ff  <= in_rem - trial;
            root_ff <= in_root | (61'd1 << BIT);
         end else begin
            rem_ff  <= in_rem;
            root_ff <= in_root;
         end
      end
   end

   assign out_rem  = rem_ff;
   assign out_root = root_ff;

endmodule

// ===== rtl/sun_ecliptic_position_core.sv =====
// Low-precision Sun position: each day number gives ecliptic x and y in signed
// Q1.30 AU. The core is a stall-all pipeline that takes one word per cycle
// while no output word is held waiting; it runs three chains of CORDIC cells
// and the 61-cell square root, with delay lines aligning the eccentric-anomaly
// and square-root paths. The whole pipeline holds while the output word waits
// to be taken. Write configuration registers only when no word is in flight.
module sun_ecliptic_position_core #(
   parameter int ANGLE_BITS      = 32,
   parameter int COORD_FRAC_BITS = 30,
   parameter int CORDIC_STAGES   = 32
) (
   input  logic        clock,
   input  logic        reset,
   sep_req_if.sink     req_if,
   sep_rsp_if.source   rsp_if,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   localparam int AB    = ANGLE_BITS;
   localparam int LC    = CORDIC_STAGES + 1;
   localparam int CE    = 2 * LC + 11;
   localparam int SQ    = sep_pkg::SQRT_BITS + 4;
   localparam int ALIGN = (CE > SQ) ? CE : SQ;
   localparam int VLD_N = ALIGN + LC + 9;
   localparam int OSH   = sep_pkg::FRAC - COORD_FRAC_BITS;
   localparam int ASH   = sep_pkg::FRAC - AB;

   // configuration
   logic [31:0]        ecc_base_ff, anom_base_ff, peri_base_ff;
   logic signed [31:0] ecc_rate_ff;
   logic signed [47:0] anom_rate_ff, peri_rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ecc_base_ff  <= 32'd71764609;
         ecc_rate_ff  <= -32'sd323972;
         anom_base_ff <= 32'd4247806169;
         anom_rate_ff <= 48'sd770616137000;
         peri_base_ff <= 32'd3375610465;
         peri_rate_ff <= 48'sd36821345;
      end else if (csr_we) begin
         case (csr_index)
            sep_pkg::CSR_ECC_BASE:  ecc_base_ff  <= csr_wdata[31:0];
            sep_pkg::CSR_ECC_RATE:  ecc_rate_ff  <= signed'(csr_wdata[31:0]);
            sep_pkg::CSR_ANOM_BASE: anom_base_ff <= csr_wdata[31:0];
            sep_pkg::CSR_ANOM_RATE: anom_rate_ff <= signed'(csr_wdata);
            sep_pkg::CSR_PERI_BASE: peri_base_ff <= csr_wdata[31:0];
            sep_pkg::CSR_PERI_RATE: peri_rate_ff <= signed'(csr_wdata);
            default: ;
         endcase
      end
   end

   // pipeline control: everything advances together
   logic en;
   logic vld_ff [VLD_N];

   assign en           = !vld_ff[VLD_N-1] || rsp_if.ready;
   assign req_if.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < VLD_N; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_if.valid;
         for (int k = 1; k < VLD_N; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // element products, then sums
   logic signed [52:0] pe_ff;
   logic [47:0]        pm_ff, pw_ff;
   logic signed [68:0] pm_full, pw_full;
   logic signed [53:0] e_sum;
   logic [47:0]        e48, m_sum, w_sum;
   sep_pkg::q60_type   e_ff;
   logic [AB-1:0]      m_ff, w_ff;

   assign pm_full = 69'(anom_rate_ff) * 69'(req_if.day_number);
   assign pw_full = 69'(peri_rate_ff) * 69'(req_if.day_number);
   assign e_sum   = signed'({6'd0, ecc_base_ff, 16'd0}) + 54'(pe_ff);
   assign e48     = e_sum[53] ? 48'd0 : ((e_sum[52:48] != 5'd0) ? {48{1'b1}} : e_sum[47:0]);
   assign m_sum   = {anom_base_ff, 16'd0} + pm_ff;
   assign w_sum   = {peri_base_ff, 16'd0} + pw_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pe_ff <= 53'(ecc_rate_ff) * 53'(req_if.day_number);
         pm_ff <= pm_full[47:0];
         pw_ff <= pw_full[47:0];
         e_ff  <= signed'({4'd0, e48, 12'd0});
         m_ff  <= m_sum[47 -: AB];
         w_ff  <= w_sum[47 -: AB];
      end
   end

   // mean anomaly sine and cosine, then the eccentric anomaly estimate
   sep_pkg::q60_type cm, sm, e_c, p1, p2, p3, corr;
   sep_pkg::q60_type t_ff, p2_ff;
   logic [AB-1:0]    m_d, ea_ff;
   sep_pkg::q60_type corr_sh;

   sep_cordic #(.AB(AB), .CS(CORDIC_STAGES)) u_cordic_m (
      .clock (clock), .en (en),
      .src_x (sep_pkg::GAIN_Q60), .src_y ('0), .src_ang (m_ff),
      .res_x (cm), .res_y (sm)
   );

   sep_delay #(.W(64), .DEPTH(LC)) u_dly_e_c (
      .clock (clock), .en (en), .d (e_ff), .q (e_c)
   );

   sep_mul u_mul_ecm (.clock (clock), .en (en), .a (e_c), .b (cm), .p (p1));
   sep_mul u_mul_esm (.clock (clock), .en (en), .a (e_c), .b (sm), .p (p2));

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff  <= sep_pkg::ONE_Q60 + p1;
         p2_ff <= p2;
      end
   end

   sep_mul u_mul_corr (.clock (clock), .en (en), .a (p2_ff), .b (t_ff), .p (p3));
   sep_mul u_mul_turn (.clock (clock), .en (en), .a (p3), .b (sep_pkg::INV2PI_Q60),
                       .p (corr));

   sep_delay #(.W(AB), .DEPTH(LC + 10)) u_dly_m (
      .clock (clock), .en (en), .d (m_ff), .q (m_d)
   );

   assign corr_sh = corr >>> ASH;

   always_ff @(posedge clock) begin
      if (en) begin
         ea_ff <= m_d + corr_sh[AB-1:0];
      end
   end

   // eccentric anomaly sine and cosine
   sep_pkg::q60_type ce, se, ce_al, se_al, e_al;

   sep_cordic #(.AB(AB), .CS(CORDIC_STAGES)) u_cordic_e (
      .clock (clock), .en (en),
      .src_x (sep_pkg::GAIN_Q60), .src_y ('0), .src_ang (ea_ff),
      .res_x (ce), .res_y (se)
   );

   sep_delay #(.W(128), .DEPTH(ALIGN - CE)) u_dly_cs (
      .clock (clock), .en (en), .d ({ce, se}), .q ({ce_al, se_al})
   );

   sep_delay #(.W(64), .DEPTH(ALIGN - LC)) u_dly_e_al (
      .clock (clock), .en (en), .d (e_c), .q (e_al)
   );

   // sqrt(1 - e^2) by a chain of root cells
   sep_pkg::q60_type ee, q_ff, root_al;
   logic [123:0]     rems  [sep_pkg::SQRT_BITS+1];
   logic [60:0]      roots [sep_pkg::SQRT_BITS+1];

   sep_mul u_mul_ee (.clock (clock), .en (en), .a (e_ff), .b (e_ff), .p (ee));

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= sep_pkg::ONE_Q60 - ee;
      end
   end

   assign rems[0]  = {q_ff, {60{1'b1}}};
   assign roots[0] = '0;

   generate
      for (genvar k = 0; k < sep_pkg::SQRT_BITS; k++) begin : g_root
         sep_sqrt_cell #(.BIT(sep_pkg::SQRT_BITS - 1 - k)) u_cell (
            .clock    (clock),
            .en       (en),
            .in_rem   (rems[k]),
            .in_root  (roots[k]),
            .out_rem  (rems[k+1]),
            .out_root (roots[k+1])
         );
      end
   endgenerate

   sep_delay #(.W(64), .DEPTH(ALIGN - SQ)) u_dly_root (
      .clock (clock), .en (en), .d ({3'd0, roots[sep_pkg::SQRT_BITS]}), .q (root_al)
   );

   // orbit-plane vector, gain pre-scale, rotation by perihelion
   sep_pkg::q60_type xv, xv_d, yv, xg, yg, xr, yr;
   logic [AB-1:0]    w_d;

   sep_delay #(.W(64), .DEPTH(3)) u_dly_xv (
      .clock (clock), .en (en), .d (ce_al - e_al), .q (xv_d)
   );
   assign xv = xv_d;

   sep_mul u_mul_yv (.clock (clock), .en (en), .a (root_al), .b (se_al), .p (yv));
   sep_mul u_mul_xg (.clock (clock), .en (en), .a (xv), .b (sep_pkg::GAIN_Q60), .p (xg));
   sep_mul u_mul_yg (.clock (clock), .en (en), .a (yv), .b (sep_pkg::GAIN_Q60), .p (yg));

   sep_delay #(.W(AB), .DEPTH(ALIGN + 6)) u_dly_w (
      .clock (clock), .en (en), .d (w_ff), .q (w_d)
   );

   sep_cordic #(.AB(AB), .CS(CORDIC_STAGES)) u_cordic_w (
      .clock (clock), .en (en),
      .src_x (xg), .src_y (yg), .src_ang (w_d),
      .res_x (xr), .res_y (yr)
   );

   // scale and saturate into the output word
   sep_pkg::q60_type   xs, ys;
   logic signed [31:0] x_ff, y_ff;

   assign xs = xr >>> OSH;
   assign ys = yr >>> OSH;

   always_ff @(posedge clock) begin
      if (en) begin
         if (xs > 64'sh7FFF_FFFF)          x_ff <= 32'sh7FFF_FFFF;
         else if (xs < -64'sh8000_0000)    x_ff <= -32'sh8000_0000;
         else                              x_ff <= xs[31:0];
         if (ys > 64'sh7FFF_FFFF)          y_ff <= 32'sh7FFF_FFFF;
         else if (ys < -64'sh8000_0000)    y_ff <= -32'sh8000_0000;
         else                              y_ff <= ys[31:0];
      end
   end

   assign rsp_if.valid = vld_ff[VLD_N-1];
   assign rsp_if.x_pos = x_ff;
   assign rsp_if.y_pos = y_ff;

   a_stall_only_on_full: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> rsp_if.valid)
      else $error("pipeline held without a waiting output word");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid)
      else $error("output word valid straight after reset");

   a_drain_advances: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready && !vld_ff[VLD_N-2] |=> !rsp_if.valid)
      else $error("output word repeated");

endmodule
